// ----- rtl/core/ordered_event_queue_defines.svh -----
// Assertion macros for the ordered event queue.
`ifndef ORDERED_EVENT_QUEUE_DEFINES_SVH
`define ORDERED_EVENT_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define OEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OEQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/oeq_pkg.sv -----
package oeq_pkg;

    localparam int DATE_W = 48;
    localparam int ID_W   = 16;
    localparam int OCC_W  = 7;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_POP      = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] KIND_INSERTED = 2'd0;
    localparam logic [1:0] KIND_RELEASED = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        logic [DATE_W-1:0] date;
        logic [ID_W-1:0]   rank;
        logic [ID_W-1:0]   block;
        logic [ID_W-1:0]   tag;
    } slot_t;

    typedef struct packed {
        cell_op_t op;
        logic     ordered;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/ordered_event_queue.sv -----
// Insert: the insert state strobes the result and returns to idle before the next insert is taken.
// Release and pop: the drain state strobes the first result, then one per cycle.
// The next transaction is taken in the cycle the final result is strobed.
// The receiver cannot stall; busy is high while a transaction is in the cell row.
// Reset empties the queue and clears the date, the peak and the mode register.
`include "ordered_event_queue_defines.svh"

module ordered_event_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [47:0] event_date,
    input  logic [15:0] tie_rank,
    input  logic [15:0] block_id,
    input  logic [15:0] event_tag,
    input  logic [47:0] limit_time,
    input  logic        order_mode_we,
    input  logic        order_mode,
    output logic        done,
    output logic [1:0]  kind,
    output logic [47:0] out_date,
    output logic [15:0] out_tag,
    output logic [15:0] out_block,
    output logic [47:0] now_date,
    output logic [6:0]  occupancy,
    output logic [6:0]  peak_occupancy,
    output logic        last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DRAIN
    } state_t;

    state_t                     state_reg;
    logic [1:0]                 cmd_reg;
    oeq_pkg::slot_t             key_reg;
    logic [47:0]                limit_reg;
    logic                       mode_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           peak_reg;
    logic [47:0]                sim_date_reg;
    logic                       done_reg;
    logic [1:0]                 kind_reg;
    logic [47:0]                out_date_reg;
    logic [15:0]                out_tag_reg;
    logic [15:0]                out_block_reg;
    logic                       last_reg;

    oeq_pkg::cell_ctrl_t        ctrl;
    oeq_pkg::slot_t             cell_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]       place_chain;
    logic [QUEUE_DEPTH:0]       seen_chain;
    logic                       full;
    logic                       head_due;
    logic                       more;
    logic                       accept;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_due = (count_reg != '0)
                      && ((cmd_reg == oeq_pkg::CMD_POP) || (cell_data[0].date <= limit_reg));
    assign more     = (cmd_reg == oeq_pkg::CMD_RELEASE) && (count_reg > CNT_W'(1))
                      && (cell_data[1].date <= limit_reg);

    always_comb
    begin
        ctrl.ordered = mode_reg;
        ctrl.op      = oeq_pkg::OP_HOLD;
        if ((state_reg == ST_INSERT) && !full)
        begin
            ctrl.op = oeq_pkg::OP_INSERT;
        end
        else if ((state_reg == ST_DRAIN) && head_due)
        begin
            ctrl.op = oeq_pkg::OP_SHIFT;
        end
    end

    assign place_chain[0] = 1'b0;
    assign seen_chain[0]  = 1'b0;

    for (genvar j = 0; j < QUEUE_DEPTH; j++)
    begin : g_cell
        oeq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (key_reg),
            .occupied   (count_reg > CNT_W'(j)),
            .left_data  ((j == 0) ? key_reg : cell_data[(j == 0) ? 0 : j - 1]),
            .right_data ((j == QUEUE_DEPTH - 1) ? key_reg
                         : cell_data[(j == QUEUE_DEPTH - 1) ? j : j + 1]),
            .place_in   (place_chain[j]),
            .seen_in    (seen_chain[j]),
            .place_out  (place_chain[j+1]),
            .seen_out   (seen_chain[j+1]),
            .data       (cell_data[j])
        );
    end

    assign count_next = count_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= oeq_pkg::CMD_INSERT;
            key_reg       <= '0;
            limit_reg     <= '0;
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            peak_reg      <= '0;
            sim_date_reg  <= '0;
            done_reg      <= 1'b0;
            kind_reg      <= oeq_pkg::KIND_INSERTED;
            out_date_reg  <= '0;
            out_tag_reg   <= '0;
            out_block_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (order_mode_we)
            begin
                mode_reg <= order_mode;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg       <= command;
                        key_reg.date  <= event_date;
                        key_reg.rank  <= tie_rank;
                        key_reg.block <= block_id;
                        key_reg.tag   <= event_tag;
                        limit_reg     <= limit_time;
                        if (command == oeq_pkg::CMD_INSERT)
                        begin
                            state_reg <= ST_INSERT;
                        end
                        else if ((command == oeq_pkg::CMD_RELEASE)
                                 || (command == oeq_pkg::CMD_POP))
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_INSERT:
                begin
                    done_reg      <= 1'b1;
                    last_reg      <= 1'b1;
                    out_date_reg  <= '0;
                    out_tag_reg   <= '0;
                    out_block_reg <= '0;
                    state_reg     <= ST_IDLE;
                    if (full)
                    begin
                        kind_reg <= oeq_pkg::KIND_OVERFLOW;
                    end
                    else
                    begin
                        kind_reg  <= oeq_pkg::KIND_INSERTED;
                        count_reg <= count_next;
                        if (peak_reg < count_next)
                        begin
                            peak_reg <= count_next;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    done_reg <= 1'b1;
                    if (head_due)
                    begin
                        kind_reg      <= oeq_pkg::KIND_RELEASED;
                        out_date_reg  <= cell_data[0].date;
                        out_tag_reg   <= cell_data[0].tag;
                        out_block_reg <= cell_data[0].block;
                        sim_date_reg  <= cell_data[0].date;
                        count_reg     <= count_reg - CNT_W'(1);
                        last_reg      <= !more;
                        if (!more)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        kind_reg      <= oeq_pkg::KIND_NONE;
                        out_date_reg  <= '0;
                        out_tag_reg   <= '0;
                        out_block_reg <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done           = done_reg;
    assign kind           = kind_reg;
    assign out_date       = out_date_reg;
    assign out_tag        = out_tag_reg;
    assign out_block      = out_block_reg;
    assign now_date       = sim_date_reg;
    assign occupancy      = 7'(count_reg);
    assign peak_occupancy = 7'(peak_reg);
    assign last           = last_reg;

    `OEQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `OEQ_ASSERT_NOW(a_peak_covers, clk, rst_n, 1'b1, peak_reg >= count_reg)
    `OEQ_ASSERT_NEXT(a_insert_busy, clk, rst_n, accept && (command == oeq_pkg::CMD_INSERT), busy)
    `OEQ_ASSERT_NOW(a_overflow_full, clk, rst_n,
                    done_reg && (kind_reg == oeq_pkg::KIND_OVERFLOW), full)

endmodule

// ----- rtl/core/oeq_cell.sv -----
module oeq_cell (
    input  logic                clk,
    input  oeq_pkg::cell_ctrl_t ctrl,
    input  oeq_pkg::slot_t      key,
    input  logic                occupied,
    input  oeq_pkg::slot_t      left_data,
    input  oeq_pkg::slot_t      right_data,
    input  logic                place_in,
    input  logic                seen_in,
    output logic                place_out,
    output logic                seen_out,
    output oeq_pkg::slot_t      data
);

    oeq_pkg::slot_t slot_reg;
    logic           same_date;
    logic           later_date;
    logic           stop_here;
    logic           candidate;
    logic           place_here;

    // The tie scan starts at the first ranked same-date entry whose rank is not below the key.
    assign same_date  = occupied && (slot_reg.date == key.date);
    assign later_date = occupied && (slot_reg.date > key.date);
    assign stop_here  = same_date && (slot_reg.rank != '0) && (slot_reg.rank >= key.rank);
    assign seen_out   = seen_in || stop_here;
    assign candidate  = ctrl.ordered && same_date && seen_out
                        && ((slot_reg.rank != key.rank) || (slot_reg.block > key.block));
    assign place_here = !occupied || later_date || candidate;
    assign place_out  = place_in || place_here;
    assign data       = slot_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            oeq_pkg::OP_INSERT:
            begin
                if (place_in)
                begin
                    slot_reg <= left_data;
                end
                else if (place_here)
                begin
                    slot_reg <= key;
                end
            end
            oeq_pkg::OP_SHIFT:
            begin
                slot_reg <= right_data;
            end
            default:
            begin
                slot_reg <= slot_reg;
            end
        endcase
    end

endmodule

// ----- sim/ordered_event_queue_tb.sv -----
module ordered_event_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] event_date;
        logic [15:0] tie_rank;
        logic [15:0] block_id;
        logic [15:0] event_tag;
        logic [47:0] limit_time;
    } txn_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] out_date;
        logic [15:0] out_tag;
        logic [15:0] out_block;
        logic [47:0] now_date;
        logic [6:0]  occupancy;
        logic [6:0]  peak_occupancy;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [47:0] event_date;
    logic [15:0] tie_rank;
    logic [15:0] block_id;
    logic [15:0] event_tag;
    logic [47:0] limit_time;
    logic        order_mode_we;
    logic        order_mode;
    logic        done;
    logic [1:0]  kind;
    logic [47:0] out_date;
    logic [15:0] out_tag;
    logic [15:0] out_block;
    logic [47:0] now_date;
    logic [6:0]  occupancy;
    logic [6:0]  peak_occupancy;
    logic        last;

    ordered_event_queue dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .event_date(event_date), .tie_rank(tie_rank),
        .block_id(block_id), .event_tag(event_tag), .limit_time(limit_time),
        .order_mode_we(order_mode_we), .order_mode(order_mode), .done(done),
        .kind(kind), .out_date(out_date), .out_tag(out_tag),
        .out_block(out_block), .now_date(now_date), .occupancy(occupancy),
        .peak_occupancy(peak_occupancy), .last(last)
    );

    logic [47:0] q_date [DEPTH];
    logic [15:0] q_rank [DEPTH];
    logic [15:0] q_block [DEPTH];
    logic [15:0] q_tag [DEPTH];
    int          q_count;
    int          q_peak;
    logic [47:0] q_now;
    logic        q_mode;

    txn_t    pending_txns[$];
    result_t expected_results[$];
    int      mismatches;
    int      results_seen;
    int      idle_pct;
    bit      driver_enable;

    function automatic int find_slot(logic [47:0] d, logic [15:0] r, logic [15:0] b);
        int lo;
        int hi;
        int it;
        lo = 0;
        while (lo < q_count && q_date[lo] < d) lo++;
        hi = lo;
        while (hi < q_count && q_date[hi] == d) hi++;
        if (!q_mode || lo == hi) return hi;
        it = lo;
        while (it < hi) begin
            if (q_rank[it] == 0) begin
                it++;
                continue;
            end
            if (q_rank[it] > r) break;
            if (q_rank[it] == r) begin
                while (it < hi && q_rank[it] == r) begin
                    if (q_block[it] > b) break;
                    it++;
                end
                break;
            end
            it++;
        end
        return it;
    endfunction

    function automatic result_t make_result(logic [1:0] k, logic [47:0] d, logic [15:0] t,
                                            logic [15:0] b, logic l);
        result_t res;
        res.kind = k;
        res.out_date = d;
        res.out_tag = t;
        res.out_block = b;
        res.now_date = q_now;
        res.occupancy = q_count[6:0];
        res.peak_occupancy = q_peak[6:0];
        res.last = l;
        return res;
    endfunction

    task automatic predict_queue(txn_t tx);
        int pos;
        int n;
        bit more;
        logic [47:0] d;
        logic [15:0] t;
        logic [15:0] b;
        n = 0;
        if (tx.command == oeq_pkg::CMD_INSERT) begin
            if (q_count >= DEPTH) begin
                expected_results.push_back(
                    make_result(oeq_pkg::KIND_OVERFLOW, '0, '0, '0, 1'b1));
                return;
            end
            pos = find_slot(tx.event_date, tx.tie_rank, tx.block_id);
            for (int i = q_count; i > pos; i--) begin
                q_date[i] = q_date[i-1];
                q_rank[i] = q_rank[i-1];
                q_block[i] = q_block[i-1];
                q_tag[i] = q_tag[i-1];
            end
            q_date[pos] = tx.event_date;
            q_rank[pos] = tx.tie_rank;
            q_block[pos] = tx.block_id;
            q_tag[pos] = tx.event_tag;
            q_count++;
            if (q_peak < q_count) q_peak = q_count;
            expected_results.push_back(make_result(oeq_pkg::KIND_INSERTED, '0, '0, '0, 1'b1));
            return;
        end
        if (tx.command != oeq_pkg::CMD_RELEASE && tx.command != oeq_pkg::CMD_POP) return;
        while (q_count > 0
               && (tx.command == oeq_pkg::CMD_POP || q_date[0] <= tx.limit_time)) begin
            d = q_date[0];
            t = q_tag[0];
            b = q_block[0];
            q_now = d;
            for (int i = 1; i < q_count; i++) begin
                q_date[i-1] = q_date[i];
                q_rank[i-1] = q_rank[i];
                q_block[i-1] = q_block[i];
                q_tag[i-1] = q_tag[i];
            end
            q_count--;
            more = (tx.command == oeq_pkg::CMD_RELEASE) && q_count > 0
                   && q_date[0] <= tx.limit_time;
            expected_results.push_back(make_result(oeq_pkg::KIND_RELEASED, d, t, b, !more));
            n++;
            if (tx.command == oeq_pkg::CMD_POP || !more) break;
        end
        if (n == 0)
            expected_results.push_back(make_result(oeq_pkg::KIND_NONE, '0, '0, '0, 1'b1));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("ordered_event_queue_tb: done, errors");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !busy)
        begin
            if (driver_enable && pending_txns.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                predict_queue(pending_txns[0]);
                {command, event_date, tie_rank, block_id, event_tag, limit_time} <=
                    pending_txns.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
        else if (!start && driver_enable && pending_txns.size() > 0
                 && $urandom_range(99) >= idle_pct)
        begin
            predict_queue(pending_txns[0]);
            {command, event_date, tie_rank, block_id, event_tag, limit_time} <=
                pending_txns.pop_front();
            start <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && done)
        begin
            got = {kind, out_date, out_tag, out_block, now_date, occupancy,
                   peak_occupancy, last};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    function automatic txn_t rand_txn(int phase_bias);
        txn_t tx;
        int sel;
        tx.command = oeq_pkg::CMD_INSERT;
        sel = $urandom_range(99);
        if (sel >= phase_bias)
            tx.command = ($urandom_range(3) == 0) ? oeq_pkg::CMD_POP : oeq_pkg::CMD_RELEASE;
        if ($urandom_range(49) == 0) tx.command = oeq_pkg::CMD_RESERVED;
        tx.event_date = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                                  : 48'($urandom_range(40));
        tx.tie_rank = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        tx.block_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        tx.event_tag = 16'($urandom);
        tx.limit_time = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                                  : 48'($urandom_range(40));
        return tx;
    endfunction

    task automatic write_mode(logic m);
        @(posedge clk);
        order_mode_we <= 1'b1;
        order_mode <= m;
        q_mode = m;
        @(posedge clk);
        order_mode_we <= 1'b0;
    endtask

    task automatic drain;
        driver_enable = 1'b1;
        while (pending_txns.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        driver_enable = 1'b0;
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        txn_t tx;
        int idles[4];
        idles = '{0, 72, 0, 9};
        rst_n = 1'b0;
        start = 1'b0;
        command = oeq_pkg::CMD_INSERT;
        event_date = '0;
        tie_rank = '0;
        block_id = '0;
        event_tag = '0;
        limit_time = '0;
        order_mode_we = 1'b0;
        order_mode = 1'b0;
        q_count = 0;
        q_peak = 0;
        q_now = '0;
        q_mode = 1'b0;
        mismatches = 0;
        results_seen = 0;
        idle_pct = 0;
        driver_enable = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty release and pop, extremes, same-date ties in both modes.
        tx = '0;
        tx.command = oeq_pkg::CMD_POP;
        pending_txns.push_back(tx);
        tx.command = oeq_pkg::CMD_RELEASE;
        tx.limit_time = '1;
        pending_txns.push_back(tx);
        tx.command = oeq_pkg::CMD_RESERVED;
        pending_txns.push_back(tx);
        tx = '{oeq_pkg::CMD_INSERT, '1, '1, '1, '1, '0};
        pending_txns.push_back(tx);
        tx = '{oeq_pkg::CMD_INSERT, 48'd5, 16'd0, 16'd7, 16'h0001, '0};
        pending_txns.push_back(tx);
        tx = '{oeq_pkg::CMD_INSERT, 48'd5, 16'd2, 16'd3, 16'h0002, '0};
        pending_txns.push_back(tx);
        tx = '{oeq_pkg::CMD_INSERT, 48'd0, 16'd0, 16'd0, 16'h0000, '0};
        pending_txns.push_back(tx);
        tx = '{oeq_pkg::CMD_RELEASE, '0, '0, '0, '0, 48'd5};
        pending_txns.push_back(tx);
        drain();
        write_mode(1'b1);
        for (int i = 0; i < 8; i++)
        begin
            tx = '{oeq_pkg::CMD_INSERT, 48'd9, 16'(i % 3), 16'(7 - i), 16'(i), '0};
            pending_txns.push_back(tx);
        end
        tx = '{oeq_pkg::CMD_POP, '0, '0, '0, '0, '0};
        pending_txns.push_back(tx);
        tx = '{oeq_pkg::CMD_RELEASE, '0, '0, '0, '0, '1};
        pending_txns.push_back(tx);
        tx = '{oeq_pkg::CMD_POP, '0, '0, '0, '0, '0};
        pending_txns.push_back(tx);
        drain();

        // Fill past capacity to reach overflow, then empty it.
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            tx = '{oeq_pkg::CMD_INSERT, 48'($urandom_range(4)), 16'($urandom_range(2)),
                   16'($urandom_range(2)), 16'($urandom), '0};
            pending_txns.push_back(tx);
        end
        tx = '{oeq_pkg::CMD_RELEASE, '0, '0, '0, '0, '1};
        pending_txns.push_back(tx);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_mode(ph[0]);
            idle_pct = idles[ph % 4];
            for (int i = 0; i < 42; i++) pending_txns.push_back(rand_txn((ph % 2) ? 70 : 55));
            drain();
        end

        $display("covered %0d results over realtime and deterministic ordering,", results_seen);
        $display("including empty releases, pops, overflow and sender idling");
        if (mismatches == 0)
        begin
            $display("ordered_event_queue_tb: done, clean");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("ordered_event_queue_tb: done, errors");
        end
        $finish;
    end
endmodule
